>>> rtl/wnd_pkg.sv
package wnd_pkg;

  localparam int unsigned YearW  = 13;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned WeekW  = 6;
  localparam int unsigned DoyW   = 9;

  localparam logic [YearW-1:0] MinYear = 13'd1753;
  localparam logic [YearW-1:0] MaxYear = 13'd8000;

  // Weekday codes, Monday = 1 .. Sunday = 7.
  localparam logic [2:0] Thursday = 3'd4;
  localparam logic [2:0] Friday   = 3'd5;
  localparam logic [2:0] Saturday = 3'd6;

  localparam logic [WeekW-1:0] LongYearWeeks  = 6'd53;
  localparam logic [WeekW-1:0] ShortYearWeeks = 6'd52;

  typedef logic [YearW-1:0] year_t;
  typedef logic [DoyW-1:0]  doy_t;

  // Days in the month for a common year; codes that are not months give 0.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before this one for a common year.
  function automatic doy_t days_before(input logic [MonthW-1:0] m);
    doy_t n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Quotient by 100 through a reciprocal; exact for any 13-bit value.
  function automatic logic [6:0] div100(input year_t x);
    logic [25:0] p;
    p = 26'(x) * 26'd5243;
    return p[25:19];
  endfunction

  // Remainder by 7 of a 14-bit value through a reciprocal.
  function automatic logic [2:0] mod7_14(input logic [13:0] x);
    logic [31:0] p;
    logic [13:0] q;
    logic [13:0] r;
    p = 32'(x) * 32'd37450;
    q = p[31:18];
    r = x - 14'(q * 14'd7);
    return r[2:0];
  endfunction

endpackage

>>> rtl/week_number_of_date.sv
// Week number of a Gregorian date. A request (year, month, day) is taken on
// every clock edge at which start is high; busy never rises, so a new date
// may follow in every cycle. Each request gives exactly one result, shown
// for one cycle with out_valid high; the receiver cannot hold results off,
// so it must take every strobed result. The work is split over three
// register stages: the first divides the year by 100 and forms the weekday
// sum of January 1, the second finds leap years, the weekday of January 1
// and the day of the year, and the third divides the day count by seven
// and picks the week. With start_on_monday set (the reset value) weeks
// follow ISO 8601; with it clear, weeks start on Sunday and a year that
// opens on a Friday or a Saturday hands its first days to the last week
// of the previous year. A year outside 1753 to 8000, a month outside 1
// to 12 or a day that is zero or past the month's end gives out_date_ok
// low and zero fields. The mode register is written through the cfg port,
// which is always ready; write it only while no request is in flight.
module week_number_of_date (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        start,
  output logic        busy,
  input  logic [12:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  // Result channel
  output logic        out_valid,
  output logic        out_date_ok,
  output logic [5:0]  out_week_number,
  output logic [12:0] out_week_year,
  // Mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_start_on_monday
);

  logic mode_r;

  // Input register.
  logic                 v0_r;
  wnd_pkg::year_t       y0_r;
  logic [3:0]           m0_r;
  logic [4:0]           d0_r;

  // Stage one.
  logic                 v1_r;
  wnd_pkg::year_t       y1_r;
  logic [4:0]           d1_r;
  wnd_pkg::doy_t        dbase1_r;
  logic [4:0]           mlen1_r;
  logic                 mgt2_1_r;
  logic                 meq2_1_r;
  logic                 ok1_r;
  logic [13:0]          sum1_r;
  logic [6:0]           qy1_r;
  logic [6:0]           qyy1_r;

  // Stage two.
  logic                 v2_r;
  wnd_pkg::year_t       y2_r;
  logic                 ok2_r;
  wnd_pkg::doy_t        doy2_r;
  logic [2:0]           jan2_r;
  logic                 leap2_r;
  logic                 leapp2_r;

  // Result register.
  logic                 out_valid_r;
  logic                 out_date_ok_r;
  logic [5:0]           out_week_number_r;
  wnd_pkg::year_t       out_week_year_r;

  // The block never stalls a request, and the mode register takes any write.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_valid) begin
      mode_r <= cfg_start_on_monday;
    end
  end

  // ---------------------------------------------------------------------
  // Stage one: range checks, month tables and the weekday sum of
  // January 1, y-1 + (y-1)/4 - (y-1)/100 + (y-1)/400 + 1.
  // ---------------------------------------------------------------------
  wnd_pkg::year_t yy;
  logic [6:0]     qyy;
  logic [13:0]    sum_nxt;
  logic           ok_nxt;

  always_comb begin
    yy      = y0_r - 13'd1;
    qyy     = wnd_pkg::div100(yy);
    sum_nxt = 14'(yy) + 14'(yy[12:2]) - 14'(qyy) + 14'(qyy[6:2]) + 14'd1;
    ok_nxt  = (y0_r >= wnd_pkg::MinYear) && (y0_r <= wnd_pkg::MaxYear) &&
              (m0_r >= 4'd1) && (m0_r <= 4'd12) && (d0_r != 5'd0);
  end

  // ---------------------------------------------------------------------
  // Stage two: leap years of this and the previous year, day of year,
  // final month-length check and the weekday of January 1.
  // ---------------------------------------------------------------------
  logic       leap;
  logic       leapp;
  logic [2:0] jmod;
  logic [2:0] jan_nxt;
  logic [5:0] mlen;

  always_comb begin
    leap    = (y1_r[1:0] == 2'd0) &&
              ((y1_r != 13'(13'(qy1_r) * 13'd100)) || (qy1_r[1:0] == 2'd0));
    leapp   = (y1_r[1:0] == 2'd1) &&
              ((13'(y1_r - 13'd1) != 13'(13'(qyy1_r) * 13'd100)) ||
               (qyy1_r[1:0] == 2'd0));
    jmod    = wnd_pkg::mod7_14(sum1_r);
    jan_nxt = (jmod == 3'd0) ? 3'd7 : jmod;
    mlen    = 6'(mlen1_r) + 6'(meq2_1_r && leap);
  end

  // ---------------------------------------------------------------------
  // Stage three: with x = doy + jan1 - 2, the weekday minus one is x mod 7
  // and the week count (doy + 7 - dow + jan1 - 1) / 7 is x / 7 + 1.
  // ---------------------------------------------------------------------
  logic [8:0]  x;
  logic [20:0] xp;
  logic [6:0]  q;
  logic [8:0]  rr;
  logic [2:0]  dow;
  logic [2:0]  sdow;
  logic [5:0]  wk_base;
  logic [5:0]  wk_sun;
  logic        late_jan1;
  logic [8:0]  total;
  logic [9:0]  tail;
  logic [5:0]  wk;
  wnd_pkg::year_t wy;

  always_comb begin
    x         = doy2_r + 9'(jan2_r) - 9'd2;
    xp        = 21'(x) * 21'd2341;
    q         = xp[20:14];
    rr        = x - 9'(9'(q) * 9'd7);
    dow       = rr[2:0] + 3'd1;
    sdow      = (dow == 3'd7) ? 3'd0 : dow;
    wk_base   = 6'(q) + 6'd1;
    // A Sunday counts in the following week when weeks start on Sunday.
    wk_sun    = wk_base + 6'(dow == 3'd7);
    late_jan1 = (jan2_r > wnd_pkg::Thursday);
    total     = leap2_r ? 9'd366 : 9'd365;
    tail      = 10'(total) - 10'(doy2_r);
    wk        = wk_base;
    wy        = y2_r;

    if (mode_r) begin
      priority if (late_jan1 && (10'(doy2_r) + 10'(jan2_r) <= 10'd8)) begin
        // Early January days belong to the last week of the previous year.
        wy = y2_r - 13'd1;
        wk = ((jan2_r == wnd_pkg::Friday) ||
              ((jan2_r == wnd_pkg::Saturday) && leapp2_r)) ?
             wnd_pkg::LongYearWeeks : wnd_pkg::ShortYearWeeks;
      end else if ((dow < wnd_pkg::Thursday) &&
                   (tail + 10'(dow) < 10'd4)) begin
        // Late December days fall in week one of the next year.
        wy = y2_r + 13'd1;
        wk = 6'd1;
      end else begin
        wy = y2_r;
        wk = wk_base - 6'(late_jan1);
      end
    end else begin
      priority if (((jan2_r == wnd_pkg::Friday) || (jan2_r == wnd_pkg::Saturday)) &&
                   (10'(doy2_r) + 10'(jan2_r) <= 10'd7)) begin
        wy = y2_r - 13'd1;
        wk = (jan2_r == wnd_pkg::Saturday) ?
             wnd_pkg::LongYearWeeks : wnd_pkg::ShortYearWeeks;
      end else if ((sdow < wnd_pkg::Thursday) &&
                   (tail + 10'(sdow) < 10'd4)) begin
        wy = y2_r + 13'd1;
        wk = 6'd1;
      end else begin
        wy = y2_r;
        wk = wk_sun - 6'(late_jan1);
      end
    end
  end

  // Control state of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= start;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start) begin
      y0_r <= in_year_in;
      m0_r <= in_month_in;
      d0_r <= in_day_in;
    end
    y1_r     <= y0_r;
    d1_r     <= d0_r;
    dbase1_r <= wnd_pkg::days_before(m0_r) + 9'(d0_r);
    mlen1_r  <= wnd_pkg::month_len(m0_r);
    mgt2_1_r <= (m0_r > 4'd2);
    meq2_1_r <= (m0_r == 4'd2);
    ok1_r    <= ok_nxt;
    sum1_r   <= sum_nxt;
    qy1_r    <= wnd_pkg::div100(y0_r);
    qyy1_r   <= qyy;

    y2_r     <= y1_r;
    ok2_r    <= ok1_r && (6'(d1_r) <= mlen);
    doy2_r   <= dbase1_r + 9'(mgt2_1_r && leap);
    jan2_r   <= jan_nxt;
    leap2_r  <= leap;
    leapp2_r <= leapp;

    out_date_ok_r     <= ok2_r;
    out_week_number_r <= ok2_r ? wk : 6'd0;
    out_week_year_r   <= ok2_r ? wy : 13'd0;
  end

  assign out_valid       = out_valid_r;
  assign out_date_ok     = out_date_ok_r;
  assign out_week_number = out_week_number_r;
  assign out_week_year   = out_week_year_r;

endmodule

>>> test/tb_week_number_of_date.sv
`timescale 1ns / 100ps

// Testbench for week_number_of_date.
//
// Dates go in through the start/busy request port, one request per
// accepted edge. A monitor process records every accepted request and
// works out the week number and week-year it should produce. The same
// process compares each strobed result with the oldest outstanding
// prediction. The week rules are computed here from a plain day count since
// 1 January of year 1 (proleptic Gregorian, which fell on a Monday), so
// nothing is shared with the arithmetic inside the block.
module tb_week_number_of_date;

  // Weekday numbering used by the predictor, Monday = 1 .. Sunday = 7.
  localparam int WdMonday   = 1;
  localparam int WdThursday = 4;
  localparam int WdFriday   = 5;
  localparam int WdSaturday = 6;
  localparam int WdPerWeek  = 7;

  // Mode register values.
  localparam logic ModeSunday = 1'b0;
  localparam logic ModeMonday = 1'b1;

  // Cycles to let pass after the last result, and the idle limit of the
  // watchdog.
  localparam int SettleCycles = 8;
  localparam int IdleLimit    = 500;

  typedef struct packed {
    logic        date_ok;
    logic [5:0]  week;
    logic [12:0] week_year;
  } week_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [12:0] in_year_in = '0;
  logic [3:0]  in_month_in = '0;
  logic [4:0]  in_day_in = '0;
  logic        out_valid;
  logic        out_date_ok;
  logic [5:0]  out_week_number;
  logic [12:0] out_week_year;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_start_on_monday = 1'b0;

  // Predictions waiting for their result, oldest first.
  week_result_t expected_weeks[$];

  // Mode the block is believed to be in; it follows every accepted write.
  logic monday_mode = ModeMonday;

  int errors = 0;
  int results_checked = 0;
  int invalid_seen = 0;
  int prior_year_seen = 0;
  int next_year_seen = 0;
  int idle_cycles = 0;

  // Sender burst state: requests left in the current burst.
  int burst_left = 0;

  week_number_of_date DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_year_in          (in_year_in),
    .in_month_in         (in_month_in),
    .in_day_in           (in_day_in),
    .out_valid           (out_valid),
    .out_date_ok         (out_date_ok),
    .out_week_number     (out_week_number),
    .out_week_year       (out_week_year),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_start_on_monday (cfg_start_on_monday)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Calendar arithmetic for the predictor
  // ---------------------------------------------------------------------

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Day of the year, 1 for January 1. Month must be 1 to 12.
  function automatic int day_of_year(input int y, input int m, input int d);
    int n;
    n = d;
    for (int k = 1; k < m; k++) n += days_in_month(y, k);
    return n;
  endfunction

  // Weekday from the running day count; day 1 of year 1 was a Monday.
  function automatic int weekday_of(input int y, input int doy);
    int days;
    days = 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + doy;
    return ((days - 1) % WdPerWeek) + WdMonday;
  endfunction

  // Week number and week-year of one date under the given week start.
  function automatic week_result_t week_of_date(input int y, input int m, input int d,
                                                input logic monday_start);
    week_result_t r;
    int doy, dow, jan1, year_len, first_day, wk, wy;
    r = '0;
    if (y < 1753 || y > 8000 || m < 1 || m > 12 || d < 1 || d > days_in_month(y, m))
      return r;
    doy = day_of_year(y, m, d);
    dow = weekday_of(y, doy);
    jan1 = weekday_of(y, 1);
    year_len = leap_year(y) ? 366 : 365;
    if (monday_start) begin
      // ISO 8601: week 1 holds the year's first Thursday.
      first_day = dow;
      if (jan1 > WdThursday && doy <= 8 - jan1) begin
        wy = y - 1;
        wk = (jan1 == WdFriday || (jan1 == WdSaturday && leap_year(y - 1))) ? 53 : 52;
        r.date_ok = 1'b1;
        r.week = wk[5:0];
        r.week_year = wy[12:0];
        return r;
      end
    end else begin
      // Sunday start: a year opening on Friday or Saturday gives its first
      // days to the previous year's last week.
      first_day = dow % WdPerWeek;
      if ((jan1 == WdFriday || jan1 == WdSaturday) && doy <= WdPerWeek - jan1) begin
        wy = y - 1;
        wk = (jan1 == WdSaturday) ? 53 : 52;
        r.date_ok = 1'b1;
        r.week = wk[5:0];
        r.week_year = wy[12:0];
        return r;
      end
    end
    if (first_day < WdThursday && year_len - doy < WdThursday - first_day) begin
      // Late December days that already sit in next year's first week.
      wy = y + 1;
      wk = 1;
    end else begin
      wy = y;
      wk = (doy + (WdPerWeek - first_day) + (jan1 - 1)) / WdPerWeek;
      if (jan1 > WdThursday) wk--;
    end
    r.date_ok = 1'b1;
    r.week = wk[5:0];
    r.week_year = wy[12:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: records accepted requests, checks results, follows the mode
  // register and keeps the watchdog. All signals are read at the clock
  // edge, before any update scheduled for that edge takes effect.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    week_result_t want;
    logic         progress;
    progress = 1'b0;
    if (!rst_n) begin
      monday_mode = ModeMonday;
    end else begin
      if (out_valid === 1'b1) begin
        progress = 1'b1;
        if (expected_weeks.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding: ok=%0b week=%0d year=%0d",
                   $time, out_date_ok, out_week_number, out_week_year);
        end else begin
          want = expected_weeks.pop_front();
          results_checked++;
          if (!want.date_ok) invalid_seen++;
          if (out_date_ok !== want.date_ok) begin
            errors++;
            $display("%0t: date_ok expected %0b, got %0b", $time, want.date_ok, out_date_ok);
          end
          if (out_week_number !== want.week) begin
            errors++;
            $display("%0t: week_number expected %0d, got %0d",
                     $time, want.week, out_week_number);
          end
          if (out_week_year !== want.week_year) begin
            errors++;
            $display("%0t: week_year expected %0d, got %0d",
                     $time, want.week_year, out_week_year);
          end
        end
      end
      if (start && busy === 1'b0) begin
        progress = 1'b1;
        want = week_of_date(int'(in_year_in), int'(in_month_in), int'(in_day_in),
                            monday_mode);
        if (want.date_ok && want.week_year < in_year_in) prior_year_seen++;
        if (want.date_ok && want.week_year > in_year_in) next_year_seen++;
        expected_weeks.push_back(want);
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        progress = 1'b1;
        monday_mode = cfg_start_on_monday;
      end
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, IdleLimit, expected_weeks.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Sends one date. Requests come in bursts of random length; between
  // bursts the sender may drop start for a random number of cycles. Returns
  // at the edge where the request was taken.
  task automatic send_date(input logic [12:0] y, input logic [3:0] m, input logic [4:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b1;
    in_year_in <= y;
    in_month_in <= m;
    in_day_in <= d;
    do @(posedge clk); while (busy !== 1'b0);
    burst_left--;
  endtask

  // Lowers start and waits until every outstanding result has come back,
  // then lets the pipeline settle so the block is idle.
  task automatic wait_all_results();
    start <= 1'b0;
    burst_left = 0;
    while (expected_weeks.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes the week-start mode; only called with the block idle.
  task automatic write_week_start(input logic mode);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_start_on_monday <= mode;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // Builds a random request. Most are valid dates with the year, January
  // and December edges favored, since that is where the week rules branch;
  // the rest are raw field values, many of them invalid.
  task automatic random_date(output logic [12:0] y, output logic [3:0] m,
                             output logic [4:0] d);
    int yy, mm;
    if ($urandom_range(0, 4) == 0) begin
      y = 13'($urandom);
      m = 4'($urandom);
      d = 5'($urandom);
    end else begin
      case ($urandom_range(0, 7))
        0:       yy = $urandom_range(1753, 1770);
        1:       yy = $urandom_range(7980, 8000);
        default: yy = $urandom_range(1753, 8000);
      endcase
      case ($urandom_range(0, 3))
        0:       mm = 1;
        1:       mm = 12;
        default: mm = $urandom_range(1, 12);
      endcase
      y = yy[12:0];
      m = mm[3:0];
      if ($urandom_range(0, 2) == 0)
        d = (mm == 1) ? 5'($urandom_range(1, 8))
                      : 5'($urandom_range(24, days_in_month(yy, mm)));
      else
        d = 5'($urandom_range(1, days_in_month(yy, mm)));
    end
  endtask

  // Field extremes, out-of-range dates, leap rules and the week-boundary
  // cases: years opening on each critical weekday and late December days
  // that belong to the next year's first week.
  task automatic send_calendar_edges();
    send_date(13'd0, 4'd0, 5'd0);        // every input bit low
    send_date(13'd8191, 4'd15, 5'd31);   // every input bit high
    send_date(13'd1752, 4'd12, 5'd31);   // year just below range
    send_date(13'd8001, 4'd1, 5'd1);     // year just above range
    send_date(13'd1753, 4'd1, 5'd1);     // first valid date
    send_date(13'd8000, 4'd12, 5'd31);   // last valid date
    send_date(13'd2023, 4'd13, 5'd5);    // month past December
    send_date(13'd2023, 4'd4, 5'd31);    // day past a 30-day month
    send_date(13'd2023, 4'd6, 5'd0);     // day zero
    send_date(13'd2024, 4'd2, 5'd29);    // leap day
    send_date(13'd2023, 4'd2, 5'd29);    // leap day in a common year
    send_date(13'd1900, 4'd2, 5'd29);    // century that is not leap
    send_date(13'd2000, 4'd2, 5'd29);    // century divisible by 400
    send_date(13'd2010, 4'd1, 5'd1);     // year opening on Friday
    send_date(13'd2011, 4'd1, 5'd1);     // year opening on Saturday
    send_date(13'd2005, 4'd1, 5'd2);     // Saturday opening after a leap year
    send_date(13'd2022, 4'd1, 5'd1);     // Saturday opening after a common year
    send_date(13'd2016, 4'd1, 5'd3);     // Friday opening, third day
    send_date(13'd2012, 4'd1, 5'd1);     // year opening on Sunday
    send_date(13'd2015, 4'd12, 5'd31);   // Thursday year with week 53
    send_date(13'd2018, 4'd12, 5'd31);   // Monday that is next year's week 1
    send_date(13'd2019, 4'd12, 5'd30);   // Monday that is next year's week 1
    send_date(13'd2024, 4'd12, 5'd29);   // Sunday near year end
    send_date(13'd2020, 4'd12, 5'd31);   // leap year ending on Thursday
    send_date(13'd2021, 4'd6, 5'd15);    // ordinary mid-year date
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Monday start is the reset value, so no register write comes first.
  task automatic test_iso_edges_after_reset();
    send_calendar_edges();
  endtask

  task automatic test_sunday_edges();
    write_week_start(ModeSunday);
    send_calendar_edges();
  endtask

  task automatic test_random_dates(input logic mode, input int count);
    logic [12:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    write_week_start(mode);
    for (int i = 0; i < count; i++) begin
      random_date(y, m, d);
      send_date(y, m, d);
    end
  endtask

  // The sender holds off until every result is back, several times over,
  // so the block also sees requests arriving into an empty pipeline.
  task automatic test_pause_between_batches();
    logic [12:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    int          batch_len;
    write_week_start(ModeMonday);
    for (int batch = 0; batch < 10; batch++) begin
      batch_len = $urandom_range(3, 12);
      for (int i = 0; i < batch_len; i++) begin
        random_date(y, m, d);
        send_date(y, m, d);
      end
      wait_all_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_iso_edges_after_reset();
    test_sunday_edges();
    test_random_dates(ModeSunday, 250);
    test_random_dates(ModeMonday, 250);
    test_random_dates(ModeSunday, 100);
    test_pause_between_batches();

    wait_all_results();
    $display("Checked %0d week results in both week-start modes: %0d invalid dates,",
             results_checked, invalid_seen);
    $display("%0d dates in the prior week-year and %0d in the next.",
             prior_year_seen, next_year_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
